### sv/fbgn_pkg.sv
package fbgn_pkg;

  localparam int unsigned LANES = 4;

  localparam logic [31:0] HASH_OFFSET = 32'd67890;
  localparam logic [31:0] HASH_MULT   = 32'd445593459;
  localparam logic [31:0] SEED_RESET  = 32'd67890;

  // Octave scales and weights, both with 16 fraction bits.
  localparam logic [19:0] OCT_SCALE [LANES] = '{20'd65536, 20'd150733, 20'd283116, 20'd568328};
  localparam logic [18:0] OCT_WEIGHT [LANES] = '{19'd432538, 19'd171704, 19'd30802, 19'd11141};

  // Width of one weighted octave term (32-bit octave value times 20-bit weight).
  localparam int unsigned TERM_W = 52;

  localparam int unsigned OUT_W = 19;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;

  // Quotient bound of the output range times five, and the reciprocal of five.
  localparam int unsigned DIV_W      = 22;
  localparam int          SAT_SPAN   = 1310720;
  localparam logic [DIV_W-1:0] DIV5_MULT = 22'd3355444;
  localparam int unsigned DIV5_SHIFT = 24;

endpackage

### sv/fbgn_octave.sv
module fbgn_octave #(
  parameter int FRAC_BITS = 16,
  parameter int OCTAVE    = 0
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [31:0]                   coordinate,
  input  logic [31:0]                          seed,
  output logic signed [fbgn_pkg::TERM_W-1:0]   weighted
);

  localparam int F  = FRAC_BITS;
  localparam int SX = 32 + F;
  localparam int MW = F + 34;
  localparam logic [19:0] SCALE  = fbgn_pkg::OCT_SCALE[OCTAVE];
  localparam logic [18:0] WEIGHT = fbgn_pkg::OCT_WEIGHT[OCTAVE];
  localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
  localparam logic [F:0]   ONE       = (F+1)'(1) << F;

  // Stage 1: scaled coordinate.
  logic signed [52:0] prod;
  // Stage 2: hash inputs and squared fraction.
  logic [31:0]  a0, a1;
  logic [F-1:0] f2, f_s2;
  // Stage 3: seeded hashes and smoothstep.
  logic [31:0]  h0_s3, h1_s3;
  logic [F:0]   t_s3;
  logic [F-1:0] f_s3;
  // Stage 4: squared hashes.
  logic [31:0]  sq0, sq1, h0_s4, h1_s4;
  logic [F:0]   t_s4;
  logic [F-1:0] f_s4;
  // Stage 5: gradients.
  logic signed [31:0] g0, g1;
  logic [F:0]   t_s5;
  logic [F-1:0] f_s5;
  // Stage 6: dot products.
  logic signed [31:0] d0, d1;
  logic [F:0]   t_s6;
  // Stage 7: blend products.
  logic signed [MW-1:0] m0, m1;
  // Stage 8: octave value.
  logic signed [31:0] oct;

  logic signed [36:0]   scaled;
  logic signed [SX-1:0] scaled_ext;
  logic [31:0]          idx;
  logic [F-1:0]         frac;
  logic [2*F-1:0]       f2_prod;
  logic [F+1:0]         t_poly;
  logic [2*F+1:0]       t_prod;
  logic [31:0]          hm0, hm1;
  logic [31:0]          c0, c1;
  logic signed [F:0]    f_ext, f_minus_one;
  logic signed [F+32:0] pd0, pd1;
  logic [F:0]           one_minus_t;
  logic signed [MW:0]   blend;

  always_comb begin
    scaled      = prod[52:16];
    scaled_ext  = SX'(scaled);
    idx         = scaled_ext[F+31:F];
    frac        = scaled[F-1:0];
    f2_prod     = frac * frac;
    t_poly      = THREE_ONE - {1'b0, f_s2, 1'b0};
    t_prod      = f2 * t_poly;
    hm0         = a0 * fbgn_pkg::HASH_MULT;
    hm1         = a1 * fbgn_pkg::HASH_MULT;
    c0          = sq0 * h0_s4;
    c1          = sq1 * h1_s4;
    f_ext       = $signed({1'b0, f_s5});
    f_minus_one = $signed({1'b1, f_s5});
    pd0         = g0 * f_ext;
    pd1         = g1 * f_minus_one;
    one_minus_t = ONE - t_s6;
    blend       = (MW+1)'(m0) + (MW+1)'(m1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= coordinate * $signed({1'b0, SCALE});

      a0       <= idx + fbgn_pkg::HASH_OFFSET;
      a1       <= idx + 32'd1 + fbgn_pkg::HASH_OFFSET;
      f2       <= f2_prod[2*F-1:F];
      f_s2     <= frac;

      h0_s3    <= hm0 ^ seed;
      h1_s3    <= hm1 ^ seed;
      t_s3     <= t_prod[2*F:F];
      f_s3     <= f_s2;

      sq0      <= h0_s3 * h0_s3;
      sq1      <= h1_s3 * h1_s3;
      h0_s4    <= h0_s3;
      h1_s4    <= h1_s3;
      t_s4     <= t_s3;
      f_s4     <= f_s3;

      g0       <= $signed({~c0[31], c0[30:0]});
      g1       <= $signed({~c1[31], c1[30:0]});
      t_s5     <= t_s4;
      f_s5     <= f_s4;

      d0       <= pd0[F+32:F+1];
      d1       <= pd1[F+32:F+1];
      t_s6     <= t_s5;

      m0       <= d0 * $signed({1'b0, one_minus_t});
      m1       <= d1 * $signed({1'b0, t_s6});

      oct      <= blend[F+31:F];

      weighted <= oct * $signed({1'b0, WEIGHT});
    end
  end

endmodule

### sv/fbgn_final.sv
module fbgn_final #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [fbgn_pkg::TERM_W-1:0]  weighted [fbgn_pkg::LANES],
  output logic signed [fbgn_pkg::OUT_W-1:0]   noise_value
);

  localparam int AW   = 55;
  localparam int M_SH = 46 - FRAC_BITS;
  localparam int QN   = AW + 1 - M_SH;
  localparam int QW   = (QN > 23) ? QN : 23;
  localparam int DW   = fbgn_pkg::DIV_W;
  localparam logic signed [AW-1:0] FOUR     = AW'(4) << 46;
  localparam logic signed [AW:0]   HALF_DEN = (AW+1)'(5) << (M_SH - 1);
  localparam logic signed [QW-1:0] SPAN     = QW'(fbgn_pkg::SAT_SPAN);

  logic signed [AW-1:0] acc;
  logic [DW-1:0]        qo;
  logic                 sat_hi, sat_lo;

  logic signed [AW:0]      qsum;
  logic signed [QN-1:0]    q;
  logic signed [QW-1:0]    qe;
  logic signed [QW-1:0]    qoff;
  logic [2*DW-1:0]         dprod;
  logic [fbgn_pkg::OUT_W-1:0] quo;

  always_comb begin
    qsum  = (AW+1)'(acc) + HALF_DEN;
    q     = qsum[AW:M_SH];
    qe    = QW'(q);
    qoff  = qe + SPAN;
    dprod = qo * fbgn_pkg::DIV5_MULT;
    quo   = dprod[fbgn_pkg::DIV5_SHIFT+fbgn_pkg::OUT_W-1:fbgn_pkg::DIV5_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc    <= AW'(weighted[0]) + AW'(weighted[1]) + AW'(weighted[2])
                + AW'(weighted[3]) + FOUR;
      sat_hi <= (qe >= SPAN);
      sat_lo <= (qe < -SPAN);
      qo     <= qoff[DW-1:0];
      if (sat_hi) begin
        noise_value <= fbgn_pkg::OUT_MAX;
      end else if (sat_lo) begin
        noise_value <= fbgn_pkg::OUT_MIN;
      end else begin
        noise_value <= $signed({~quo[fbgn_pkg::OUT_W-1], quo[fbgn_pkg::OUT_W-2:0]});
      end
    end
  end

endmodule

### sv/fbm_gradient_noise_1d_top.sv
// Four-octave fractal sum of 1D gradient noise on a fixed-point coordinate.
// The coordinate channel (in_valid, in_ready, coordinate) takes one signed
// sample position per transaction, with FRAC_BITS fraction bits. The result
// channel (out_valid, out_ready, noise_value) returns one saturated value per
// transaction, in the order the coordinates arrived.
// The seed is written through the configuration channel (cfg_valid,
// cfg_ready, cfg_data); cfg_ready is always high. The seed is read at the third
// pipeline stage, so a new seed also reaches coordinates still in the first two
// stages, and it should therefore be written only while the pipeline is empty.
// The datapath is a twelve-stage pipeline: nine stages per octave, the four
// octaves running side by side, then summing, rounding and the division by
// five. One coordinate is accepted in every cycle while the pipeline is not
// frozen.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready falls; nothing is dropped or repeated.
// Reset empties the pipeline and restores the seed to its reset value.
module fbm_gradient_noise_1d_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [31:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 coordinate,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fbgn_pkg::OUT_W-1:0]  noise_value
);

  localparam int DEPTH = 12;

  logic [31:0]      seed;
  logic [DEPTH-1:0] vld;
  logic             adv;
  logic signed [fbgn_pkg::TERM_W-1:0] weighted [fbgn_pkg::LANES];

  assign adv       = !vld[DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= fbgn_pkg::SEED_RESET;
      vld  <= '0;
    end else begin
      if (cfg_valid) begin
        seed <= cfg_data;
      end
      if (adv) begin
        vld <= {vld[DEPTH-2:0], in_valid};
      end
    end
  end

  for (genvar k = 0; k < fbgn_pkg::LANES; k++) begin : g_oct
    fbgn_octave #(
      .FRAC_BITS (FRAC_BITS),
      .OCTAVE    (k)
    ) u_octave (
      .clk        (clk),
      .en         (adv),
      .coordinate (coordinate),
      .seed       (seed),
      .weighted   (weighted[k])
    );
  end

  fbgn_final #(
    .FRAC_BITS (FRAC_BITS)
  ) u_final (
    .clk         (clk),
    .en          (adv),
    .weighted    (weighted),
    .noise_value (noise_value)
  );

endmodule
